// ----- src/dsct_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, constants, types and divisor functions for the degree sine/cosine unit.
package dsct_pkg;

  // Number of series terms for both sine and cosine.
  localparam int SERIES_TERMS = 7;

  // Angle reduction.
  localparam int DEG_W       = 16;
  localparam int MAG_W       = 17;
  localparam int QUOT_W      = 9;
  localparam int ANGLE_W     = 9;
  localparam int FULL_TURN   = 360;
  localparam int MOD_RECIP   = 93207;   // ceil(2^25 / 360)
  localparam int MOD_SHIFT   = 25;
  localparam int MOD_PROD_W  = MAG_W + MAG_W;

  // Radians in unsigned Q32.
  localparam int RAD_PER_DEG = 74961321;
  localparam int X_W         = 35;
  localparam int XHI_W       = X_W + X_W - 16;
  localparam int XLO_W       = X_W + 16;
  localparam int X2_W        = XHI_W - 16;

  // Series terms and their products.
  localparam int TERM_W      = 40;
  localparam int SUM_W       = 42;
  localparam int PROD_W      = TERM_W + X2_W - 16;
  localparam int LO_W        = TERM_W + 16;
  localparam int P_W         = PROD_W - 16;
  localparam int SPLIT_W     = 23;
  localparam int HIGH_W      = P_W - SPLIT_W;
  localparam int DIV_W       = 9;
  localparam int REM_W       = DIV_W + 1;
  localparam int RECIP_W     = DIV_W + SPLIT_W;

  localparam logic [TERM_W-1:0] ONE_Q32 = TERM_W'(64'h1_0000_0000);

  // Output conversion.
  localparam int RES_W       = 32;
  localparam int ROUND_SHIFT = 4;
  localparam int ROUND_BIAS  = 8;
  localparam logic [RES_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] SAT_NEG = 32'h8000_0000;

  // Pipeline depths.
  localparam int FRONT_STAGES = 6;
  localparam int CELL_STAGES  = 7;
  localparam int ROUND_STAGES = 3;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic [SUM_W-1:0]  sum;
  } lane_t;

  // Divisor that turns sine term k-1 into term k: (2k)(2k+1).
  function automatic logic [DIV_W-1:0] sine_div(input int k);
    sine_div = DIV_W'((2 * k) * (2 * k + 1));
  endfunction

  // Divisor that turns cosine term k-1 into term k: (2k-1)(2k).
  function automatic logic [DIV_W-1:0] cosine_div(input int k);
    cosine_div = DIV_W'((2 * k - 1) * (2 * k));
  endfunction

endpackage

// ----- src/degree_sine_cosine_taylor_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per clock cycle; busy is high only while rst is high.
// The rate is set by the fully pipelined chain of term cells, one cell per series term after the zeroth.
// Reset (synchronous, active high) clears every valid bit; transactions in flight are dropped.
// done pulses for exactly one cycle per transaction; the receiver cannot stall the unit.
module degree_sine_cosine_taylor_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dsct_pkg::DEG_W-1:0]  degrees,
  output logic                        done,
  output logic [dsct_pkg::RES_W-1:0]  sine_value,
  output logic [dsct_pkg::RES_W-1:0]  cosine_value
);

  // Chain taps: index 0 is the output of the front end, index k the output of cell k.
  dsct_pkg::ctl_t             ctl_chain  [dsct_pkg::SERIES_TERMS];
  logic [dsct_pkg::X2_W-1:0]  x2_chain   [dsct_pkg::SERIES_TERMS];
  dsct_pkg::lane_t            sine_chain [dsct_pkg::SERIES_TERMS];
  dsct_pkg::lane_t            cos_chain  [dsct_pkg::SERIES_TERMS];

  logic [dsct_pkg::X_W-1:0]   x;
  logic [dsct_pkg::ROUND_STAGES-1:0] done_pipe;

  // There is no stored state between transactions, so the unit only holds off
  // new work while it is being reset.
  assign busy = rst;

  // The front end folds the sign away, reduces the magnitude modulo 360 with a
  // reciprocal multiply, converts to Q32 radians and forms x squared.
  dsct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (start & ~busy),
    .degrees (degrees),
    .ctl_out (ctl_chain[0]),
    .x_out   (x),
    .x2_out  (x2_chain[0])
  );

  // The zeroth terms: x for sine and one for cosine, each also the starting sum.
  assign sine_chain[0].term = dsct_pkg::TERM_W'(x);
  assign sine_chain[0].sum  = dsct_pkg::SUM_W'(x);
  assign cos_chain[0].term  = dsct_pkg::ONE_Q32;
  assign cos_chain[0].sum   = dsct_pkg::SUM_W'(dsct_pkg::ONE_Q32);

  // Each cell derives term k from term k-1 by a multiply with x squared and an
  // exact truncating division by a constant, then adds or subtracts it from the
  // running sum. The division uses a fixed reciprocal worked out here, so the
  // cells themselves stay identical.
  for (genvar k = 1; k < dsct_pkg::SERIES_TERMS; k++) begin : g_cell
    localparam logic [dsct_pkg::DIV_W-1:0] SineDiv = dsct_pkg::sine_div(k);
    localparam logic [dsct_pkg::DIV_W-1:0] CosDiv  = dsct_pkg::cosine_div(k);
    localparam logic [dsct_pkg::RECIP_W-1:0] SINE_RECIP =
      dsct_pkg::RECIP_W'((64'd1 << dsct_pkg::RECIP_W) / SineDiv);
    localparam logic [dsct_pkg::RECIP_W-1:0] COS_RECIP =
      dsct_pkg::RECIP_W'((64'd1 << dsct_pkg::RECIP_W) / CosDiv);
    localparam logic SUBTRACT = ((k % 2) == 1);

    dsct_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl_in       (ctl_chain[k-1]),
      .x2_in        (x2_chain[k-1]),
      .sine_in      (sine_chain[k-1]),
      .cos_in       (cos_chain[k-1]),
      .sine_divisor (SineDiv),
      .sine_recip   (SINE_RECIP),
      .cos_divisor  (CosDiv),
      .cos_recip    (COS_RECIP),
      .subtract     (SUBTRACT),
      .ctl_out      (ctl_chain[k]),
      .x2_out       (x2_chain[k]),
      .sine_out     (sine_chain[k]),
      .cos_out      (cos_chain[k])
    );
  end

  // Sine is odd, so a negative angle negates it; cosine is even and never flips.
  dsct_round u_round_sine (
    .clk   (clk),
    .sum   (sine_chain[dsct_pkg::SERIES_TERMS-1].sum),
    .flip  (ctl_chain[dsct_pkg::SERIES_TERMS-1].neg),
    .value (sine_value)
  );

  dsct_round u_round_cos (
    .clk   (clk),
    .sum   (cos_chain[dsct_pkg::SERIES_TERMS-1].sum),
    .flip  (1'b0),
    .value (cosine_value)
  );

  // The valid bit follows the sums through the output conversion.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_pipe <= '0;
    end else begin
      done_pipe <= {done_pipe[dsct_pkg::ROUND_STAGES-2:0],
                    ctl_chain[dsct_pkg::SERIES_TERMS-1].valid};
    end
  end

  assign done = done_pipe[dsct_pkg::ROUND_STAGES-1];

endmodule

// ----- src/dsct_front.sv -----
`timescale 1ns / 1ps
// Angle reduction modulo 360, conversion to Q32 radians and squaring.
module dsct_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [dsct_pkg::DEG_W-1:0]   degrees,
  output dsct_pkg::ctl_t               ctl_out,
  output logic [dsct_pkg::X_W-1:0]     x_out,
  output logic [dsct_pkg::X2_W-1:0]    x2_out
);

  logic [dsct_pkg::FRONT_STAGES-1:0] valid_pipe;
  logic [dsct_pkg::FRONT_STAGES-1:0] neg_pipe;

  logic [dsct_pkg::MAG_W-1:0]      mag1;
  logic [dsct_pkg::MAG_W-1:0]      mag2;
  logic [dsct_pkg::QUOT_W-1:0]     quot2;
  logic [dsct_pkg::ANGLE_W-1:0]    angle3;
  logic [dsct_pkg::X_W-1:0]        x4;
  logic [dsct_pkg::X_W-1:0]        x5;
  logic [dsct_pkg::XHI_W-1:0]      hi5;
  logic [dsct_pkg::XLO_W-1:0]      lo5;

  logic [dsct_pkg::MAG_W-1:0]      mag_in;
  logic [dsct_pkg::MOD_PROD_W-1:0] quot_prod;
  logic [dsct_pkg::MAG_W-1:0]      remainder;
  logic [dsct_pkg::XHI_W-1:0]      sq_sum;

  // 2^DEG_W as a magnitude: the negative input folds to its absolute value.
  function automatic logic [dsct_pkg::MAG_W-1:0] MAG_W_ONE_TURN();
    MAG_W_ONE_TURN = dsct_pkg::MAG_W'(1) << dsct_pkg::DEG_W;
  endfunction

  always_comb begin
    if (degrees[dsct_pkg::DEG_W-1]) begin
      mag_in = MAG_W_ONE_TURN() - dsct_pkg::MAG_W'(degrees);
    end else begin
      mag_in = dsct_pkg::MAG_W'(degrees);
    end
  end

  assign quot_prod = dsct_pkg::MOD_PROD_W'(mag1) * dsct_pkg::MOD_PROD_W'(dsct_pkg::MOD_RECIP);
  assign remainder = mag2 - dsct_pkg::MAG_W'(quot2) * dsct_pkg::MAG_W'(dsct_pkg::FULL_TURN);
  assign sq_sum    = hi5 + dsct_pkg::XHI_W'(lo5[dsct_pkg::XLO_W-1:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[dsct_pkg::FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    neg_pipe <= {neg_pipe[dsct_pkg::FRONT_STAGES-2:0], degrees[dsct_pkg::DEG_W-1]};
    mag1     <= mag_in;
    mag2     <= mag1;
    quot2    <= quot_prod[dsct_pkg::MOD_PROD_W-1:dsct_pkg::MOD_SHIFT];
    angle3   <= remainder[dsct_pkg::ANGLE_W-1:0];
    x4       <= dsct_pkg::X_W'(angle3) * dsct_pkg::X_W'(dsct_pkg::RAD_PER_DEG);
    x5       <= x4;
    hi5      <= dsct_pkg::XHI_W'(x4) * dsct_pkg::XHI_W'(x4[dsct_pkg::X_W-1:16]);
    lo5      <= dsct_pkg::XLO_W'(x4) * dsct_pkg::XLO_W'(x4[15:0]);
    x_out    <= x5;
    x2_out   <= sq_sum[dsct_pkg::XHI_W-1:16];
  end

  assign ctl_out.valid = valid_pipe[dsct_pkg::FRONT_STAGES-1];
  assign ctl_out.neg   = neg_pipe[dsct_pkg::FRONT_STAGES-1];

endmodule

// ----- src/dsct_term.sv -----
`timescale 1ns / 1ps
// One series term: multiply by x squared, divide by a constant, accumulate.
module dsct_term (
  input  logic                          clk,
  input  dsct_pkg::lane_t               lane_in,
  input  logic [dsct_pkg::X2_W-1:0]     x2,
  input  logic [dsct_pkg::DIV_W-1:0]    divisor,
  input  logic [dsct_pkg::RECIP_W-1:0]  recip,
  input  logic                          subtract,
  output dsct_pkg::lane_t               lane_out
);

  localparam int QE_PROD_W = dsct_pkg::RECIP_W + dsct_pkg::HIGH_W;
  localparam int Q2_PROD_W = dsct_pkg::RECIP_W + dsct_pkg::RECIP_W;

  logic [dsct_pkg::PROD_W-1:0]  hi1;
  logic [dsct_pkg::LO_W-1:0]    lo1;
  logic [dsct_pkg::P_W-1:0]     p2;
  logic [dsct_pkg::HIGH_W-1:0]  ph3;
  logic [dsct_pkg::SPLIT_W-1:0] pl3;
  logic [dsct_pkg::HIGH_W-1:0]  qe3;
  logic [dsct_pkg::HIGH_W-1:0]  qh4;
  logic [dsct_pkg::DIV_W-1:0]   rh4;
  logic [dsct_pkg::SPLIT_W-1:0] pl4;
  logic [dsct_pkg::RECIP_W-1:0] n5;
  logic [dsct_pkg::HIGH_W-1:0]  qh5;
  logic [dsct_pkg::SPLIT_W-1:0] qe5;
  logic [dsct_pkg::TERM_W-1:0]  term6;
  logic [dsct_pkg::SUM_W-1:0]   sum1, sum2, sum3, sum4, sum5, sum6;

  logic [dsct_pkg::PROD_W-1:0]  psum;
  logic [QE_PROD_W-1:0]         qe_prod;
  logic [dsct_pkg::RECIP_W-1:0] rh_diff;
  logic [dsct_pkg::REM_W-1:0]   rh_raw;
  logic [dsct_pkg::RECIP_W-1:0] n4;
  logic [Q2_PROD_W-1:0]         q2_prod;
  logic [dsct_pkg::RECIP_W-1:0] r2_diff;
  logic [dsct_pkg::REM_W-1:0]   r2_raw;
  logic [dsct_pkg::SPLIT_W-1:0] q2;

  assign psum    = hi1 + dsct_pkg::PROD_W'(lo1[dsct_pkg::LO_W-1:16]);
  assign qe_prod = QE_PROD_W'(p2[dsct_pkg::P_W-1:dsct_pkg::SPLIT_W]) * QE_PROD_W'(recip);

  // The reciprocal estimate is low by at most one; a single compare fixes it.
  assign rh_diff = dsct_pkg::RECIP_W'(ph3)
                 - dsct_pkg::RECIP_W'(qe3) * dsct_pkg::RECIP_W'(divisor);
  assign rh_raw  = rh_diff[dsct_pkg::REM_W-1:0];

  assign n4      = {rh4, pl4};
  assign q2_prod = Q2_PROD_W'(n4) * Q2_PROD_W'(recip);

  assign r2_diff = n5 - dsct_pkg::RECIP_W'(qe5) * dsct_pkg::RECIP_W'(divisor);
  assign r2_raw  = r2_diff[dsct_pkg::REM_W-1:0];
  assign q2      = (r2_raw >= dsct_pkg::REM_W'(divisor)) ? qe5 + 1'b1 : qe5;

  always_ff @(posedge clk) begin
    hi1  <= dsct_pkg::PROD_W'(lane_in.term) * dsct_pkg::PROD_W'(x2[dsct_pkg::X2_W-1:16]);
    lo1  <= dsct_pkg::LO_W'(lane_in.term) * dsct_pkg::LO_W'(x2[15:0]);
    sum1 <= lane_in.sum;

    p2   <= psum[dsct_pkg::PROD_W-1:16];
    sum2 <= sum1;

    ph3  <= p2[dsct_pkg::P_W-1:dsct_pkg::SPLIT_W];
    pl3  <= p2[dsct_pkg::SPLIT_W-1:0];
    qe3  <= qe_prod[QE_PROD_W-1:dsct_pkg::RECIP_W];
    sum3 <= sum2;

    if (rh_raw >= dsct_pkg::REM_W'(divisor)) begin
      qh4 <= qe3 + 1'b1;
      rh4 <= dsct_pkg::DIV_W'(rh_raw - dsct_pkg::REM_W'(divisor));
    end else begin
      qh4 <= qe3;
      rh4 <= rh_raw[dsct_pkg::DIV_W-1:0];
    end
    pl4  <= pl3;
    sum4 <= sum3;

    n5   <= n4;
    qh5  <= qh4;
    qe5  <= q2_prod[dsct_pkg::RECIP_W+dsct_pkg::SPLIT_W-1:dsct_pkg::RECIP_W];
    sum5 <= sum4;

    term6 <= dsct_pkg::TERM_W'({qh5, q2});
    sum6  <= sum5;

    lane_out.term <= term6;
    if (subtract) begin
      lane_out.sum <= sum6 - dsct_pkg::SUM_W'(term6);
    end else begin
      lane_out.sum <= sum6 + dsct_pkg::SUM_W'(term6);
    end
  end

endmodule

// ----- src/dsct_cell.sv -----
`timescale 1ns / 1ps
// One cell of the series chain: the same term index for sine and cosine.
module dsct_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  dsct_pkg::ctl_t                ctl_in,
  input  logic [dsct_pkg::X2_W-1:0]     x2_in,
  input  dsct_pkg::lane_t               sine_in,
  input  dsct_pkg::lane_t               cos_in,
  input  logic [dsct_pkg::DIV_W-1:0]    sine_divisor,
  input  logic [dsct_pkg::RECIP_W-1:0]  sine_recip,
  input  logic [dsct_pkg::DIV_W-1:0]    cos_divisor,
  input  logic [dsct_pkg::RECIP_W-1:0]  cos_recip,
  input  logic                          subtract,
  output dsct_pkg::ctl_t                ctl_out,
  output logic [dsct_pkg::X2_W-1:0]     x2_out,
  output dsct_pkg::lane_t               sine_out,
  output dsct_pkg::lane_t               cos_out
);

  logic [dsct_pkg::CELL_STAGES-1:0] valid_pipe;
  logic [dsct_pkg::CELL_STAGES-1:0] neg_pipe;
  logic [dsct_pkg::X2_W-1:0]        x2_pipe [dsct_pkg::CELL_STAGES];

  dsct_term u_sine (
    .clk      (clk),
    .lane_in  (sine_in),
    .x2       (x2_in),
    .divisor  (sine_divisor),
    .recip    (sine_recip),
    .subtract (subtract),
    .lane_out (sine_out)
  );

  dsct_term u_cos (
    .clk      (clk),
    .lane_in  (cos_in),
    .x2       (x2_in),
    .divisor  (cos_divisor),
    .recip    (cos_recip),
    .subtract (subtract),
    .lane_out (cos_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[dsct_pkg::CELL_STAGES-2:0], ctl_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    neg_pipe   <= {neg_pipe[dsct_pkg::CELL_STAGES-2:0], ctl_in.neg};
    x2_pipe[0] <= x2_in;
    for (int i = 1; i < dsct_pkg::CELL_STAGES; i++) begin
      x2_pipe[i] <= x2_pipe[i-1];
    end
  end

  assign ctl_out.valid = valid_pipe[dsct_pkg::CELL_STAGES-1];
  assign ctl_out.neg   = neg_pipe[dsct_pkg::CELL_STAGES-1];
  assign x2_out        = x2_pipe[dsct_pkg::CELL_STAGES-1];

endmodule

// ----- src/dsct_round.sv -----
`timescale 1ns / 1ps
// Signed Q32 sum to saturated Q3.28 with rounding half away from zero.
module dsct_round (
  input  logic                        clk,
  input  logic [dsct_pkg::SUM_W-1:0]  sum,
  input  logic                        flip,
  output logic [dsct_pkg::RES_W-1:0]  value
);

  localparam int RND_W = dsct_pkg::SUM_W + 1;
  localparam int R_W   = RND_W - dsct_pkg::ROUND_SHIFT;

  logic                       neg1;
  logic                       flip1;
  logic [dsct_pkg::SUM_W-1:0] mag1;
  logic                       sign2;
  logic [dsct_pkg::RES_W-1:0] mag2;

  logic [RND_W-1:0] rounded;
  logic [R_W-1:0]   shifted;
  logic [R_W-1:0]   limit;
  logic             sign;

  assign rounded = RND_W'(mag1) + RND_W'(dsct_pkg::ROUND_BIAS);
  assign shifted = rounded[RND_W-1:dsct_pkg::ROUND_SHIFT];
  assign sign    = neg1 ^ flip1;
  assign limit   = sign ? R_W'(dsct_pkg::SAT_NEG) : R_W'(dsct_pkg::SAT_POS);

  always_ff @(posedge clk) begin
    neg1  <= sum[dsct_pkg::SUM_W-1];
    flip1 <= flip;
    mag1  <= sum[dsct_pkg::SUM_W-1] ? dsct_pkg::SUM_W'(0) - sum : sum;

    sign2 <= sign;
    mag2  <= (shifted > limit) ? limit[dsct_pkg::RES_W-1:0] : shifted[dsct_pkg::RES_W-1:0];

    value <= sign2 ? dsct_pkg::RES_W'(0) - mag2 : mag2;
  end

endmodule
